@@ hw/rtl/frame_crop_rotate_engine_defines.svh @@
// Assertion macros shared by the RTL of the frame crop and rotate engine.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef FRAME_CROP_ROTATE_ENGINE_DEFINES_SVH
`define FRAME_CROP_ROTATE_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcr assertion failed");

`endif

@@ hw/rtl/fcr_pkg.sv @@
`timescale 1ns / 1ps
package fcr_pkg;

  localparam int unsigned DIM_W       = 9;   // frame and crop dimensions
  localparam int unsigned OFS_W       = 8;   // crop offsets
  localparam int unsigned PROD_W      = 2 * DIM_W;
  localparam int unsigned PIX_W       = 24;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned OCC_W       = 3;
  localparam int unsigned OUT_W       = PIX_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_TRANSFORM,
    REG_CROP_LEFT,
    REG_CROP_TOP,
    REG_CROP_WIDTH,
    REG_CROP_HEIGHT
  } cfg_reg_e;

  typedef enum logic {
    MODE_LOAD,
    MODE_FETCH
  } mode_e;

  typedef enum logic {
    XF_CROP,
    XF_ROTATE
  } transform_e;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    transform_e       transform;
    logic [OFS_W-1:0] crop_left;
    logic [OFS_W-1:0] crop_top;
    logic [DIM_W-1:0] crop_width;
    logic [DIM_W-1:0] crop_height;
  } cfg_t;

  // Control that travels alongside a fetch through the read pipeline.
  typedef struct packed {
    logic valid;
    logic err;
    logic last;
  } tag_t;

endpackage

@@ hw/rtl/fcr_ram.sv @@
`timescale 1ns / 1ps
module fcr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // A read of the entry being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/fcr_addr_gen.sv @@
`timescale 1ns / 1ps
module fcr_addr_gen import fcr_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned ADDR_W     = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              load_i,
  input  logic              fetch_i,
  output logic              wr_en_o,
  output logic [ADDR_W-1:0] wr_addr_o,
  output logic              rd_en_o,
  output logic [ADDR_W-1:0] rd_addr_o,
  output tag_t              s1_tag_o,
  output tag_t              s2_tag_o
);

  localparam int unsigned DIM_MAX = (1 << DIM_W) - 1;
  localparam int unsigned W_LIM   = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
  localparam int unsigned H_LIM   = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
  localparam logic [DIM_W-1:0] W_MAX = DIM_W'(W_LIM);
  localparam logic [DIM_W-1:0] H_MAX = DIM_W'(H_LIM);

  logic [DIM_W-1:0]  w, h;
  logic [PROD_W-1:0] frame_size;
  logic [PROD_W-1:0] load_q, load_d, load_cur, load_inc;

  logic [DIM_W-1:0]  row_q, row_d, col_q, col_d;
  logic [DIM_W-1:0]  ow, oh, row, col;
  logic [DIM_W:0]    crop_right, crop_bottom, col_nx, row_nx, crop_base;
  logic              bad, col_more, row_more;
  logic [DIM_W-1:0]  r_calc, c_calc;

  tag_t              s1_q, s1_d, s2_q;
  logic [DIM_W-1:0]  s1_r_q, s1_c_q;
  logic [PROD_W-1:0] rd_sum;

  // Frame size clamps into the supported range.
  always_comb begin
    if (cfg_i.frame_width == '0) begin
      w = DIM_W'(1);
    end else if (cfg_i.frame_width > W_MAX) begin
      w = W_MAX;
    end else begin
      w = cfg_i.frame_width;
    end
    if (cfg_i.frame_height == '0) begin
      h = DIM_W'(1);
    end else if (cfg_i.frame_height > H_MAX) begin
      h = H_MAX;
    end else begin
      h = cfg_i.frame_height;
    end
  end

  assign frame_size = PROD_W'(w) * PROD_W'(h);

  // Load address wraps after the last pixel of the frame.
  always_comb begin
    load_cur = (load_q >= frame_size) ? '0 : load_q;
    load_inc = load_cur + PROD_W'(1);
    load_d   = load_q;
    if (load_i) begin
      load_d = (load_inc >= frame_size) ? '0 : load_inc;
    end
  end

  assign wr_en_o   = load_i;
  assign wr_addr_o = ADDR_W'(load_cur);

  // Output position, window check and store coordinates of the next pixel.
  always_comb begin
    crop_right  = {1'b0, cfg_i.crop_left} + {1'b0, cfg_i.crop_width};
    crop_bottom = {1'b0, cfg_i.crop_top} + {1'b0, cfg_i.crop_height};
    bad = (cfg_i.transform == XF_CROP) &&
          ((cfg_i.crop_width == '0) || (cfg_i.crop_height == '0) ||
           (crop_right > {1'b0, w}) || (crop_bottom > {1'b0, h}));
    if (cfg_i.transform == XF_CROP) begin
      ow = cfg_i.crop_width;
      oh = cfg_i.crop_height;
    end else begin
      ow = h;
      oh = w;
    end
    if ((row_q >= oh) || (col_q >= ow)) begin
      row = '0;
      col = '0;
    end else begin
      row = row_q;
      col = col_q;
    end
    col_nx   = {1'b0, col} + (DIM_W+1)'(1);
    row_nx   = {1'b0, row} + (DIM_W+1)'(1);
    col_more = col_nx < {1'b0, ow};
    row_more = row_nx < {1'b0, oh};

    crop_base = {1'b0, row} + {1'b0, h} - {2'b0, cfg_i.crop_top} - {1'b0, cfg_i.crop_height};
    if (cfg_i.transform == XF_CROP) begin
      r_calc = crop_base[DIM_W-1:0];
      c_calc = col + {1'b0, cfg_i.crop_left};
    end else begin
      r_calc = col;
      c_calc = w - DIM_W'(1) - row;
    end

    row_d = row_q;
    col_d = col_q;
    s1_d  = '0;
    if (fetch_i) begin
      s1_d.valid = 1'b1;
      if (bad) begin
        row_d      = '0;
        col_d      = '0;
        s1_d.err   = 1'b1;
        s1_d.last  = 1'b1;
      end else if (col_more) begin
        row_d = row;
        col_d = col_nx[DIM_W-1:0];
      end else begin
        col_d = '0;
        if (row_more) begin
          row_d = row_nx[DIM_W-1:0];
        end else begin
          row_d     = '0;
          s1_d.last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
      s1_q   <= '0;
      s2_q   <= '0;
    end else begin
      load_q <= load_d;
      row_q  <= row_d;
      col_q  <= col_d;
      s1_q   <= s1_d;
      s2_q   <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch_i) begin
      s1_r_q <= r_calc;
      s1_c_q <= c_calc;
    end
  end

  // Linear store address: row times frame width plus column.
  assign rd_sum    = PROD_W'(s1_r_q) * PROD_W'(w) + PROD_W'(s1_c_q);
  assign rd_addr_o = ADDR_W'(rd_sum);
  assign rd_en_o   = s1_q.valid && !s1_q.err;
  assign s1_tag_o  = s1_q;
  assign s2_tag_o  = s2_q;

endmodule

@@ hw/rtl/fcr_out_queue.sv @@
`timescale 1ns / 1ps
module fcr_out_queue import fcr_pkg::*; #(
  parameter int unsigned DATA_W = 26
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o,
  output logic [OCC_W-1:0]  count_o
);

  logic [DATA_W-1:0] entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [OCC_W-1:0]  count_q, count_d;

  always_comb begin
    wp_d    = wp_q;
    rp_d    = rp_q;
    count_d = count_q;
    if (push_i) begin
      wp_d = wp_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rp_d = rp_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + OCC_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - OCC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wp_q] <= push_data_i;
    end
  end

  assign valid_o = count_q != '0;
  assign data_o  = entry_q[rp_q];
  assign count_o = count_q;

endmodule

@@ hw/rtl/frame_crop_rotate_engine.sv @@
`timescale 1ns / 1ps
// Frame store with a crop or rotate-by-ninety readout.
// Input items arrive on the s_axis channel. tuser selects the kind of item:
// a load writes the pixel in tdata into the next store entry (bottom row
// first, each row left to right, wrapping after W*H pixels); a fetch asks
// for the next output pixel in raster order and causes exactly one result.
// Results leave on the m_axis channel with tlast on the final pixel of the
// output frame and tuser set when the crop window does not fit the frame.
// A fetch's result is registered by the coordinate stage, which forms the
// store coordinates, then by the single-port-read frame RAM and the result
// queue. With m_axis_tready held high the block takes one item every cycle,
// loads and fetches mixed; the limit is the read pipeline plus a four-entry
// result queue, and s_axis_tready drops once fetches in flight and queued
// results together fill that queue, so a stalled receiver loses nothing.
// Reset clears the load address, the output position, the pipeline and the
// queue and restores the register defaults; the frame store itself is not
// cleared and must be loaded before it is fetched. Configuration writes on
// the cfg channel are always accepted and are meant for idle periods.
`include "frame_crop_rotate_engine_defines.svh"
module frame_crop_rotate_engine import fcr_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input items.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,  // blue_in, green_in, red_in
  input  logic                  s_axis_tuser,  // mode
  // Result items.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [PIX_W-1:0]      m_axis_tdata,  // blue_out, green_out, red_out
  output logic                  m_axis_tlast,
  output logic                  m_axis_tuser   // error
);

  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  cfg_t              cfg_q, cfg_d;
  logic              in_acc, load_acc, fetch_acc, out_acc;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [PIX_W-1:0]  rd_data;
  tag_t              s1_tag, s2_tag;
  logic [OUT_W-1:0]  push_data, head;
  logic [OCC_W-1:0]  q_count, occ;

  // Configuration registers; the channel never stalls.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  cfg_d.frame_width  = cfg_data_i;
        REG_FRAME_HEIGHT: cfg_d.frame_height = cfg_data_i;
        REG_TRANSFORM:    cfg_d.transform    = transform_e'(cfg_data_i[0]);
        REG_CROP_LEFT:    cfg_d.crop_left    = cfg_data_i[OFS_W-1:0];
        REG_CROP_TOP:     cfg_d.crop_top     = cfg_data_i[OFS_W-1:0];
        REG_CROP_WIDTH:   cfg_d.crop_width   = cfg_data_i;
        REG_CROP_HEIGHT:  cfg_d.crop_height  = cfg_data_i;
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= DIM_W'(1);
      cfg_q.frame_height <= DIM_W'(1);
      cfg_q.transform    <= XF_CROP;
      cfg_q.crop_left    <= '0;
      cfg_q.crop_top     <= '0;
      cfg_q.crop_width   <= DIM_W'(1);
      cfg_q.crop_height  <= DIM_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Every fetch in the read pipeline holds a reserved queue slot, so the
  // queue can never be asked to take more than it holds.
  assign occ           = OCC_W'(s1_tag.valid) + OCC_W'(s2_tag.valid) + q_count;
  assign s_axis_tready = occ < OCC_W'(QUEUE_DEPTH);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load_acc      = in_acc && (mode_e'(s_axis_tuser) == MODE_LOAD);
  assign fetch_acc     = in_acc && (mode_e'(s_axis_tuser) == MODE_FETCH);

  fcr_addr_gen #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ADDR_W     (ADDR_W)
  ) u_addr_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .load_i    (load_acc),
    .fetch_i   (fetch_acc),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .s1_tag_o  (s1_tag),
    .s2_tag_o  (s2_tag)
  );

  fcr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_frame_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (s_axis_tdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // A bad crop window yields a zero pixel with the error flag.
  assign push_data = {s2_tag.err, s2_tag.last, (s2_tag.err ? PIX_W'(0) : rd_data)};
  assign out_acc   = m_axis_tvalid && m_axis_tready;

  fcr_out_queue #(
    .DATA_W (OUT_W)
  ) u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_tag.valid),
    .push_data_i (push_data),
    .pop_i       (out_acc),
    .valid_o     (m_axis_tvalid),
    .data_o      (head),
    .count_o     (q_count)
  );

  assign m_axis_tdata = head[PIX_W-1:0];
  assign m_axis_tlast = head[PIX_W];
  assign m_axis_tuser = head[PIX_W+1];

  // Reserved slots never exceed the queue depth.
  `FCR_ASSERT_NOW(a_occ_bound, 1'b1, occ <= OCC_W'(QUEUE_DEPTH))
  // An error result always closes the frame with a zero pixel.
  `FCR_ASSERT_NOW(a_err_result, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == '0))
  // Each accepted fetch reaches the coordinate stage in the next cycle.
  `FCR_ASSERT_NEXT(a_fetch_issue, fetch_acc, s1_tag.valid)

endmodule

@@ sim/frame_checker.sv @@
`timescale 1ns / 1ps
module frame_checker import fcr_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [PIX_W-1:0]      s_tdata_i,
  input  logic                  s_tuser_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [PIX_W-1:0]      m_tdata_i,
  input  logic                  m_tlast_i,
  input  logic                  m_tuser_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic             error;
  } out_pixel_t;

  logic [PIX_W-1:0] frame_mem [STORE_DEPTH];
  int unsigned      load_ptr;
  int unsigned      row_pos;
  int unsigned      col_pos;
  cfg_t             regs;
  out_pixel_t       expected_pixels [$];
  int               fails;
  int               checked;
  string            byte_name [3] = '{"blue", "green", "red"};

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lim);
    if (v < 1) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Works out the next pixel of the output image and advances the position.
  function automatic out_pixel_t next_output_pixel(int unsigned w, int unsigned h);
    int unsigned left, top, cw, ch, ow, oh, addr;
    out_pixel_t  r;
    r    = '0;
    left = regs.crop_left;
    top  = regs.crop_top;
    cw   = regs.crop_width;
    ch   = regs.crop_height;
    if (regs.transform == XF_CROP) begin
      if (cw == 0 || ch == 0 || left + cw > w || top + ch > h) begin
        row_pos = 0;
        col_pos = 0;
        r.last  = 1'b1;
        r.error = 1'b1;
        return r;
      end
      ow = cw;
      oh = ch;
    end else begin
      ow = h;
      oh = w;
    end
    if (row_pos >= oh || col_pos >= ow) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (regs.transform == XF_CROP) begin
      addr = (row_pos + h - top - ch) * w + col_pos + left;
    end else begin
      addr = col_pos * w + (w - 1 - row_pos);
    end
    r.pixel = frame_mem[addr % STORE_DEPTH];
    if (col_pos + 1 < ow) begin
      col_pos++;
    end else begin
      col_pos = 0;
      if (row_pos + 1 < oh) begin
        row_pos++;
      end else begin
        row_pos = 0;
        r.last  = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned w, h;
    out_pixel_t  exp_px;
    if (!rst_ni) begin
      load_ptr           = 0;
      row_pos            = 0;
      col_pos            = 0;
      regs.frame_width   = 9'd1;
      regs.frame_height  = 9'd1;
      regs.transform     = XF_CROP;
      regs.crop_left     = '0;
      regs.crop_top      = '0;
      regs.crop_width    = 9'd1;
      regs.crop_height   = 9'd1;
      expected_pixels.delete();
      fails              = 0;
      checked            = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_FRAME_WIDTH:  regs.frame_width  = cfg_data_i;
          REG_FRAME_HEIGHT: regs.frame_height = cfg_data_i;
          REG_TRANSFORM:    regs.transform    = transform_e'(cfg_data_i[0]);
          REG_CROP_LEFT:    regs.crop_left    = cfg_data_i[OFS_W-1:0];
          REG_CROP_TOP:     regs.crop_top     = cfg_data_i[OFS_W-1:0];
          REG_CROP_WIDTH:   regs.crop_width   = cfg_data_i;
          REG_CROP_HEIGHT:  regs.crop_height  = cfg_data_i;
          default: ;
        endcase
      end
      w = clamp_dim(regs.frame_width, MAX_WIDTH);
      h = clamp_dim(regs.frame_height, MAX_HEIGHT);
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == MODE_LOAD) begin
          if (load_ptr >= w * h) load_ptr = 0;
          frame_mem[load_ptr % STORE_DEPTH] = s_tdata_i;
          load_ptr++;
          if (load_ptr >= w * h) load_ptr = 0;
        end else begin
          expected_pixels.push_back(next_output_pixel(w, h));
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_pixels.size() == 0) begin
          fails++;
          $display("%0t: result with no fetch waiting: expected none, got pixel %h last %b error %b",
                   $time, m_tdata_i, m_tlast_i, m_tuser_i);
        end else begin
          exp_px = expected_pixels.pop_front();
          checked++;
          for (int b = 0; b < 3; b++) begin
            if (m_tdata_i[8*b +: 8] !== exp_px.pixel[8*b +: 8]) begin
              fails++;
              $display("%0t: %s byte mismatch: expected %h, got %h", $time, byte_name[b],
                       exp_px.pixel[8*b +: 8], m_tdata_i[8*b +: 8]);
            end
          end
          if (m_tlast_i !== exp_px.last) begin
            fails++;
            $display("%0t: last flag mismatch: expected %b, got %b", $time,
                     exp_px.last, m_tlast_i);
          end
          if (m_tuser_i !== exp_px.error) begin
            fails++;
            $display("%0t: error flag mismatch: expected %b, got %b", $time,
                     exp_px.error, m_tuser_i);
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_pixels.size();
    checked_o    <= checked;
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import fcr_pkg::*;

  // Cycles to let the read pipeline and the result queue empty out after the
  // last expected result, before registers are touched.
  localparam int SETTLE_CYCLES = 8;
  // Receiver hold-off used to back the block up until it stalls its input.
  localparam int LONG_HOLD     = 300;
  // Item budget; the random loop also goes on until both large frames are done.
  localparam int ITEM_BUDGET   = 1050;
  localparam int LIMIT         = 1000000;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  s_axis_tvalid  = 1'b0;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata   = '0;
  logic                  s_axis_tuser   = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready  = 1'b0;
  logic [PIX_W-1:0]      m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  int          fail_count;
  int          pending;
  int          checked;
  int          items_sent  = 0;
  int          phase       = 0;
  int          hold_asked  = 0;
  int          hold_served = 0;
  int          cycle_count = 0;
  int unsigned cur_w       = 1;
  int unsigned cur_h       = 1;

  frame_crop_rotate_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // The checker watches all three channels, predicts every fetch and compares.
  frame_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .m_tuser_i    (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 30);
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v < 1) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  // Offers one item and returns at the edge where it is taken. tvalid stays
  // high afterwards so that back-to-back items need no extra edge.
  task automatic push_item(mode_e m, logic [PIX_W-1:0] px, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= m;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Stops offering items and waits until every fetch has been answered.
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Loads never produce a result, so the pipeline gets a few more cycles.
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_reg_e r, int unsigned v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= CFG_DATA_W'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sets the frame size and loads one whole frame, so that every entry any
  // later fetch can read has been written.
  task automatic set_frame(int unsigned wv, int unsigned hv);
    settle();
    cfg_write(REG_FRAME_WIDTH, wv);
    cfg_write(REG_FRAME_HEIGHT, hv);
    cur_w = clamp_dim(wv);
    cur_h = clamp_dim(hv);
    repeat (cur_w * cur_h) push_item(MODE_LOAD, PIX_W'($urandom()), pick_gap());
  endtask

  task automatic set_window(transform_e xf, int unsigned left_v, int unsigned top_v,
                            int unsigned cw_v, int unsigned ch_v, bit write_crop);
    settle();
    cfg_write(REG_TRANSFORM, xf);
    if (write_crop) begin
      cfg_write(REG_CROP_LEFT, left_v);
      cfg_write(REG_CROP_TOP, top_v);
      cfg_write(REG_CROP_WIDTH, cw_v);
      cfg_write(REG_CROP_HEIGHT, ch_v);
    end
  endtask

  // A stretch of fetches mixed with reloads of the current frame. Now and
  // then the sender stops and lets every answer come back first.
  task automatic run_items(int n, int load_pct, bit burst);
    mode_e m;
    repeat (n) begin
      if ($urandom_range(0, 99) < 3) wait_results();
      m = ($urandom_range(0, 99) < load_pct) ? MODE_LOAD : MODE_FETCH;
      push_item(m, PIX_W'($urandom()), burst ? 0 : pick_gap());
    end
  endtask

  // Receiver: random ready levels held for random stretches, with a long
  // hold-off whenever the stimulus asks for one.
  initial begin : sink
    int r;
    @(posedge rst_ni);
    forever begin
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      r = $urandom_range(0, 99);
      m_axis_tready <= ($urandom_range(0, 3) != 0);
      if (r < 80) repeat ($urandom_range(1, 3)) @(posedge clk_i);
      else if (r < 95) repeat ($urandom_range(4, 12)) @(posedge clk_i);
      else repeat ($urandom_range(20, 40)) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[frame_crop_rotate_engine] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned wv, hv, left, top, cw, ch, out_size;
    int          kind, n, n_sub;
    bit          burst;
    transform_e  xf;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. With the reset registers the frame is a single pixel:
    // load all ones, read it back, then all zeros, then read it rotated.
    push_item(MODE_LOAD, 24'hFFFFFF, 0);
    push_item(MODE_FETCH, '0, 0);
    push_item(MODE_LOAD, 24'h000000, 0);
    push_item(MODE_FETCH, '0, 0);
    set_window(XF_ROTATE, 0, 0, 1, 1, 1'b0);
    push_item(MODE_FETCH, '0, 0);

    // A 3 by 2 frame with a 2 by 2 window in its right part, read once
    // through and one pixel more to see the position wrap.
    settle();
    cfg_write(REG_FRAME_WIDTH, 3);
    cfg_write(REG_FRAME_HEIGHT, 2);
    cur_w = 3;
    cur_h = 2;
    set_window(XF_CROP, 1, 0, 2, 2, 1'b1);
    push_item(MODE_LOAD, 24'hFFFFFF, 0);
    push_item(MODE_LOAD, 24'h000000, 0);
    repeat (4) push_item(MODE_LOAD, PIX_W'($urandom()), 0);
    repeat (5) push_item(MODE_FETCH, '0, 0);

    // Window sticking out on the right, then a window of zero width.
    settle();
    cfg_write(REG_CROP_LEFT, 2);
    push_item(MODE_FETCH, '0, 0);
    settle();
    cfg_write(REG_CROP_LEFT, 0);
    cfg_write(REG_CROP_WIDTH, 0);
    push_item(MODE_FETCH, '0, 0);

    // Rotated readout of the same frame: 2 wide and 3 tall.
    set_window(XF_ROTATE, 0, 0, 0, 0, 1'b0);
    repeat (3) push_item(MODE_FETCH, '0, 0);

    // Random part: a series of frame setups, each followed by a few windows.
    while (items_sent < ITEM_BUDGET || phase <= 6) begin
      if (phase == 3) begin
        // Widest frame; the width register is written above its range.
        set_frame(511, 1);
        set_window(XF_CROP, 255, 0, 1, 1, 1'b1);
        run_items(3, 0, 1'b0);
        set_window(XF_CROP, 0, 0, 256, 1, 1'b1);
        run_items(20, 0, 1'b0);
        set_window(XF_ROTATE, 0, 0, 0, 0, 1'b0);
        run_items(256, 0, 1'b0);
      end else if (phase == 6) begin
        // Tallest frame; a width of zero saturates to one.
        set_frame(0, 256);
        set_window(XF_CROP, 0, 255, 1, 1, 1'b1);
        run_items(3, 0, 1'b0);
        set_window(XF_CROP, 0, 0, 1, 256, 1'b1);
        run_items(30, 10, 1'b0);
        set_window(XF_ROTATE, 0, 0, 0, 0, 1'b0);
        run_items(30, 0, 1'b0);
      end else begin
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          wv = $urandom_range(1, 8);
          hv = $urandom_range(1, 8);
        end else if (kind < 9) begin
          wv = $urandom_range(9, 24);
          hv = $urandom_range(1, 3);
        end else begin
          wv = $urandom_range(1, 3);
          hv = $urandom_range(9, 24);
        end
        set_frame(wv, hv);
        n_sub = $urandom_range(1, 3);
        for (int sub = 0; sub < n_sub; sub++) begin
          kind = $urandom_range(0, 9);
          xf   = XF_CROP;
          if (kind < 4) begin
            cw   = $urandom_range(1, cur_w);
            ch   = $urandom_range(1, cur_h);
            left = $urandom_range(0, cur_w - cw);
            top  = $urandom_range(0, cur_h - ch);
          end else if (kind == 4) begin
            cw   = cur_w;
            ch   = cur_h;
            left = 0;
            top  = 0;
          end else if (kind < 8) begin
            xf   = XF_ROTATE;
            cw   = $urandom_range(0, 511);
            ch   = $urandom_range(0, 511);
            left = $urandom_range(0, 255);
            top  = $urandom_range(0, 255);
          end else begin
            // Raw values, usually a window that does not fit.
            cw   = $urandom_range(0, 1) ? 0 : $urandom_range(0, 511);
            ch   = $urandom_range(0, 1) ? 0 : $urandom_range(0, 511);
            left = $urandom_range(0, 255);
            top  = $urandom_range(0, 255);
          end
          // Bit 8 of an offset write is dropped by the 8-bit register.
          set_window(xf, left | ($urandom_range(0, 3) == 0 ? 256 : 0),
                     top | ($urandom_range(0, 3) == 0 ? 256 : 0), cw, ch,
                     xf == XF_CROP || $urandom_range(0, 1));
          if (xf == XF_ROTATE) begin
            out_size = cur_w * cur_h;
          end else if (cw != 0 && ch != 0 && left + cw <= cur_w && top + ch <= cur_h) begin
            out_size = cw * ch;
          end else begin
            out_size = 0;
          end
          if (phase == 1 && sub == 0) begin
            // Back the block up behind a long receiver hold-off, then let
            // everything drain before going on.
            hold_asked++;
            wait (hold_served == hold_asked);
            run_items(40, 0, 1'b1);
            wait_results();
          end else begin
            n = (out_size == 0) ? $urandom_range(1, 4)
                                : out_size + $urandom_range(0, out_size);
            if (n > 40) n = 40;
            burst = ($urandom_range(0, 3) == 0);
            run_items(n, ($urandom_range(0, 9) < 7) ? 10 : 40, burst);
          end
        end
      end
      phase++;
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d items over %0d frame setups; %0d results checked in crop and rotate modes.",
             items_sent, phase, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("[frame_crop_rotate_engine] OK");
    end else begin
      $display("[frame_crop_rotate_engine] ERROR");
    end
    $finish;
  end

endmodule

@@ frame_crop_rotate_engine.f @@
+incdir+hw/rtl
hw/rtl/fcr_pkg.sv
hw/rtl/fcr_ram.sv
hw/rtl/fcr_addr_gen.sv
hw/rtl/fcr_out_queue.sv
hw/rtl/frame_crop_rotate_engine.sv
sim/frame_checker.sv
sim/testbench.sv
